// File: src/fppow_pkg.sv
`default_nettype none
package fppow_pkg;

  localparam logic [63:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] PINF_BITS = 64'h7FF0_0000_0000_0000;

  localparam int MANT_W = 53;
  localparam int PROD_W = 106;
  localparam int EXPI_W = 14;
  localparam int HALF_W = 27;

  typedef struct packed {
    logic                     sign;
    logic signed [EXPI_W-1:0] expo;
    logic [MANT_W-1:0]        mant;
    logic                     is_zero;
    logic                     is_inf;
    logic                     is_nan;
  } fp_unpacked_t;

  // Value is mant * 2^(expo-52); subnormals keep a clear leading bit.
  function automatic fp_unpacked_t unpack(input logic [63:0] b);
    fp_unpacked_t u;
    u.sign    = b[63];
    u.is_zero = (b[62:0] == 63'd0);
    u.is_inf  = (b[62:52] == 11'h7FF) && (b[51:0] == 52'd0);
    u.is_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
    if (b[62:52] == 11'd0) begin
      u.mant = {1'b0, b[51:0]};
      u.expo = -14'sd1022;
    end else begin
      u.mant = {1'b1, b[51:0]};
      u.expo = $signed({3'b000, b[62:52]}) - 14'sd1023;
    end
    return u;
  endfunction

endpackage
`default_nettype wire

// File: src/float_power_by_squaring_top.sv
`default_nettype none
// Raises a binary64 base to a signed integer power by square-and-multiply from the top set
// bit of the exponent magnitude, rounding every step to nearest-even; a negative exponent
// first replaces the base by its rounded reciprocal. One transaction is in flight at a time:
// s_tready is high only while idle. Each floating multiply runs on a single 27x27 multiplier
// taking four partial products, followed by one-bit normalise/denormalise steps and a round.
// Subnormal operands need more normalise steps. The reciprocal uses a restoring divider,
// one quotient bit a cycle. A finished result waits in the output register while the next
// transaction is accepted.
module float_power_by_squaring_top #(
  parameter int EXP_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // base_bits [63:0], exponent [64 +: EXP_WIDTH], zero padded
  input  wire logic [((64+EXP_WIDTH+7)/8)*8-1:0]   s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // power_bits [63:0]
  output logic [63:0]                              m_tdata
);

  localparam int IDX_W = $clog2(EXP_WIDTH);
  localparam int E_W   = fppow_pkg::EXPI_W;
  localparam int P_W   = fppow_pkg::PROD_W;
  localparam int H_W   = fppow_pkg::HALF_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RNORM  = 4'd1;
  localparam logic [3:0] S_RDIV   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_OPST   = 4'd4;
  localparam logic [3:0] S_MUL    = 4'd5;
  localparam logic [3:0] S_NORM   = 4'd6;
  localparam logic [3:0] S_DENORM = 4'd7;
  localparam logic [3:0] S_ROUND  = 4'd8;
  localparam logic [3:0] S_RET    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]              state;
  logic [63:0]             base_r, acc_r, res_r, fin_r;
  logic [EXP_WIDTH-1:0]    mag;
  logic [IDX_W-1:0]        bitidx;
  logic                    op_sq, in_recip;
  logic                    sgn;
  logic signed [E_W-1:0]   e;
  logic [P_W-1:0]          m;
  logic [52:0]             a_m, b_m, dv;
  logic [53:0]             rem;
  logic [55:0]             q;
  logic [5:0]              cnt;
  logic [2:0]              mstep;
  logic [2*H_W-1:0]        pp;
  logic [6:0]              pshift;

  logic [EXP_WIDTH-1:0]    raw;
  fppow_pkg::fp_unpacked_t ua, ub, ui;
  logic [63:0]             opb;
  logic [H_W-1:0]          pa, pb;
  logic [53:0]             rem_sub, rem_next;
  logic [55:0]             q_next;
  logic signed [E_W-1:0]   biased, b2;
  logic                    rinc;
  logic [53:0]             rsum;
  logic [52:0]             rmant;
  logic [10:0]             efield;
  logic [63:0]             round_res;

  assign raw      = s_tdata[64 +: EXP_WIDTH];
  assign s_tready = (state == S_IDLE);
  assign opb      = op_sq ? acc_r : base_r;
  assign ua       = fppow_pkg::unpack(acc_r);
  assign ub       = fppow_pkg::unpack(opb);
  assign ui       = fppow_pkg::unpack(s_tdata[63:0]);

  // Partial product operands: low 27 bits and high 26 bits of each mantissa
  always_comb begin
    unique case (mstep)
      3'd0:    begin pa = a_m[26:0];          pb = b_m[26:0];          end
      3'd1:    begin pa = a_m[26:0];          pb = {1'b0, b_m[52:27]}; end
      3'd2:    begin pa = {1'b0, a_m[52:27]}; pb = b_m[26:0];          end
      3'd3:    begin pa = {1'b0, a_m[52:27]}; pb = {1'b0, b_m[52:27]}; end
      default: begin pa = '0;                 pb = '0;                 end
    endcase
  end

  assign rem_sub  = rem - {1'b0, dv};
  assign rem_next = (rem >= {1'b0, dv}) ? {rem_sub[52:0], 1'b0} : {rem[52:0], 1'b0};
  assign q_next   = {q[54:0], (rem >= {1'b0, dv})};

  always_comb begin
    biased    = e + 14'sd1023;
    rinc      = m[52] & ((|m[51:0]) | m[53]);
    rsum      = {1'b0, m[105:53]} + {53'd0, rinc};
    b2        = rsum[53] ? biased + 14'sd1 : biased;
    rmant     = rsum[53] ? rsum[53:1] : rsum[52:0];
    efield    = rmant[52] ? b2[10:0] : 11'd0;
    if (b2 >= 14'sd2047) begin
      round_res = {sgn, fppow_pkg::PINF_BITS[62:0]};
    end else begin
      round_res = {sgn, efield, rmant[51:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (raw == '0) begin
              fin_r <= fppow_pkg::ONE_BITS;
              state <= S_DONE;
            end else if (raw[EXP_WIDTH-1]) begin
              mag      <= ~raw + 1'b1;
              in_recip <= 1'b1;
              sgn      <= ui.sign;
              priority if (ui.is_nan) begin
                res_r <= fppow_pkg::QNAN_BITS;
                state <= S_RET;
              end else if (ui.is_zero) begin
                res_r <= {ui.sign, fppow_pkg::PINF_BITS[62:0]};
                state <= S_RET;
              end else if (ui.is_inf) begin
                res_r <= {ui.sign, 63'd0};
                state <= S_RET;
              end else begin
                dv    <= ui.mant;
                e     <= ui.expo;
                state <= S_RNORM;
              end
            end else begin
              in_recip <= 1'b0;
              mag      <= raw;
              base_r   <= s_tdata[63:0];
              bitidx   <= IDX_W'(EXP_WIDTH-1);
              state    <= S_SCAN;
            end
          end
        end
        S_RNORM: begin
          if (!dv[52]) begin
            dv <= {dv[51:0], 1'b0};
            e  <= e - 14'sd1;
          end else begin
            rem   <= {2'b01, 52'd0};
            q     <= '0;
            cnt   <= '0;
            state <= S_RDIV;
          end
        end
        S_RDIV: begin
          q   <= q_next;
          rem <= rem_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd55) begin
            m     <= {q_next, (rem_next != 54'd0), 49'd0};
            e     <= -e;
            state <= S_NORM;
          end
        end
        S_SCAN: begin
          if (mag[bitidx]) begin
            acc_r <= base_r;
            if (bitidx == '0) begin
              state <= S_FIN;
            end else begin
              bitidx <= bitidx - 1'b1;
              op_sq  <= 1'b1;
              state  <= S_OPST;
            end
          end else begin
            bitidx <= bitidx - 1'b1;
          end
        end
        S_OPST: begin
          sgn <= ua.sign ^ ub.sign;
          priority if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_zero)
                       || (ua.is_zero && ub.is_inf)) begin
            res_r <= fppow_pkg::QNAN_BITS;
            state <= S_RET;
          end else if (ua.is_inf || ub.is_inf) begin
            res_r <= {ua.sign ^ ub.sign, fppow_pkg::PINF_BITS[62:0]};
            state <= S_RET;
          end else if (ua.is_zero || ub.is_zero) begin
            res_r <= {ua.sign ^ ub.sign, 63'd0};
            state <= S_RET;
          end else begin
            a_m   <= ua.mant;
            b_m   <= ub.mant;
            e     <= ua.expo + ub.expo + 14'sd1;
            m     <= '0;
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          pp    <= pa * pb;
          mstep <= mstep + 3'd1;
          unique case (mstep)
            3'd0, 3'd3: pshift <= (mstep == 3'd0) ? 7'd0 : 7'd54;
            default:    pshift <= 7'd27;
          endcase
          if (mstep != 3'd0) begin
            m <= m + ({52'd0, pp} << pshift);
          end
          if (mstep == 3'd4) begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          if (!m[105]) begin
            m <= {m[104:0], 1'b0};
            e <= e - 14'sd1;
          end else begin
            state <= S_DENORM;
          end
        end
        S_DENORM: begin
          if (biased < 14'sd1) begin
            if (m[105:1] != '0) begin
              m <= {1'b0, m[105:2], m[1] | m[0]};
              e <= e + 14'sd1;
            end else begin
              e <= -14'sd1022;
            end
          end else begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          res_r <= round_res;
          state <= S_RET;
        end
        S_RET: begin
          if (in_recip) begin
            in_recip <= 1'b0;
            base_r   <= res_r;
            bitidx   <= IDX_W'(EXP_WIDTH-1);
            state    <= S_SCAN;
          end else begin
            acc_r <= res_r;
            if (op_sq && mag[bitidx]) begin
              op_sq <= 1'b0;
              state <= S_OPST;
            end else if (bitidx == '0) begin
              state <= S_FIN;
            end else begin
              bitidx <= bitidx - 1'b1;
              op_sq  <= 1'b1;
              state  <= S_OPST;
            end
          end
        end
        S_FIN: begin
          fin_r <= ((acc_r[62:52] == 11'h7FF) && (acc_r[51:0] != '0))
                   ? fppow_pkg::QNAN_BITS : acc_r;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= fin_r;
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("accepted a transaction while still busy");

  a_nan_canonical: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[62:52] == 11'h7FF) && (m_tdata[51:0] != '0)
      |-> m_tdata == fppow_pkg::QNAN_BITS)
    else $error("non-canonical NaN on output");

  a_norm_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_NORM |-> m != '0)
    else $error("normalising a zero mantissa");

endmodule
`default_nettype wire
